/* sv/dbwt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dbwt_pkg
// Shared types and constants of the DNA block transform.
// ----------------------------------------------------------------------------
package dbwt_pkg;

	localparam int unsigned MaxRowsDefault = 1024;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_READ   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_INVAL = 2'd1,
		ST_OVFL  = 2'd2,
		ST_NRDY  = 2'd3
	} status_t;

	localparam logic [2:0] SymSent = 3'd0;
	localparam logic [2:0] SymA    = 3'd1;
	localparam logic [2:0] SymC    = 3'd2;
	localparam logic [2:0] SymG    = 3'd3;
	localparam logic [2:0] SymT    = 3'd4;

	localparam logic [7:0] ChrNl = 8'h0a;
	localparam logic [7:0] ChrA  = 8'h41;
	localparam logic [7:0] ChrC  = 8'h43;
	localparam logic [7:0] ChrG  = 8'h47;
	localparam logic [7:0] ChrT  = 8'h54;

	function automatic logic [2:0] base_code(input logic [7:0] b);
		case (b)
			ChrA: base_code = SymA;
			ChrC: base_code = SymC;
			ChrG: base_code = SymG;
			ChrT: base_code = SymT;
			default: base_code = SymSent;
		endcase
	endfunction

	function automatic logic [7:0] code_byte(input logic [2:0] c);
		case (c)
			SymA: code_byte = ChrA;
			SymC: code_byte = ChrC;
			SymG: code_byte = ChrG;
			SymT: code_byte = ChrT;
			default: code_byte = 8'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

/* sv/dbwt_sort.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dbwt_sort
// Bottom-up merge sort of cyclic rotations with one symbol comparator,
// then the last-column pass. Holds the text, rank, scratch and output memories.
// ----------------------------------------------------------------------------
module dbwt_sort #(
	parameter int unsigned MAX_ROWS = dbwt_pkg::MaxRowsDefault,
	parameter int unsigned AW = $clog2(MAX_ROWS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          txt_we,
	input  wire logic [AW-1:0] txt_addr,
	input  wire logic [2:0]    txt_wdata,
	input  wire logic          start,
	input  wire logic [AW-1:0] last,
	output logic               done,
	output logic [AW-1:0]      sent_row,
	input  wire logic [AW-1:0] rd_addr,
	output logic [2:0]         rd_sym
);
	import dbwt_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_INIT  = 11'b00000000010,
		S_MSET  = 11'b00000000100,
		S_RDPQ  = 11'b00000001000,
		S_RDTX  = 11'b00000010000,
		S_CMP   = 11'b00000100000,
		S_TAIL  = 11'b00001000000,
		S_COPY  = 11'b00010000000,
		S_OUTA  = 11'b00100000000,
		S_OUTB  = 11'b01000000000,
		S_OUTC  = 11'b10000000000
	} st_t;

	logic [2:0]    text_mem [MAX_ROWS];
	logic [AW-1:0] rank_mem [MAX_ROWS];
	logic [AW-1:0] tmp_mem  [MAX_ROWS];
	logic [2:0]    out_mem  [MAX_ROWS];

	st_t        st_q;
	logic [AW:0] width_q, lo_q, mid_q, hi_q, p_q, q_q, o_q, n_q;
	logic [AW-1:0] ra_q, rb_q, a_q, b_q, k_q;
	logic [2:0] x_q, y_q, ta_q;
	logic       tphase_q;
	logic [AW-1:0] rk_rd_q;
	logic [AW-1:0] tmp_rd_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] sent_q;

	logic [AW:0] mid_c, hi_c, two_w;
	logic [AW-1:0] rk_addr;

	assign two_w = width_q << 1;
	assign done = (st_q == S_IDLE);
	assign sent_row = sent_q;
	assign rk_addr = (st_q == S_TAIL && p_q >= mid_q) ? q_q[AW-1:0] : p_q[AW-1:0];

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] v, input logic [AW:0] n);
		logic [AW:0] s;
		s = {1'b0, v} + 1'b1;
		wrap = (s == n) ? '0 : s[AW-1:0];
	endfunction

	always_comb begin
		mid_c = ((lo_q + width_q) > n_q) ? n_q : lo_q + width_q;
		hi_c  = ((lo_q + two_w) > n_q) ? n_q : lo_q + two_w;
	end

	always_ff @(posedge clk) begin
		if (txt_we) begin
			text_mem[txt_addr] <= txt_wdata;
		end
		ta_q <= text_mem[a_q];
		rk_rd_q <= rank_mem[rk_addr];
		tmp_rd_q <= tmp_mem[cnt_q];
		rd_sym <= out_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			tphase_q <= 1'b0;
			sent_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (start) begin
						n_q <= {1'b0, last} + 1'b1;
						cnt_q <= '0;
						st_q <= S_INIT;
					end
				end
				S_INIT: begin
					rank_mem[cnt_q] <= cnt_q;
					if ({1'b0, cnt_q} == n_q - 1'b1) begin
						width_q <= (AW+1)'(1);
						lo_q <= '0;
						p_q <= '0;
						st_q <= ((n_q) > 1) ? S_MSET : S_OUTA;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MSET: begin
					mid_q <= mid_c;
					hi_q <= hi_c;
					p_q <= lo_q;
					q_q <= mid_c;
					o_q <= lo_q;
					st_q <= (mid_c < hi_c) ? S_RDPQ : S_TAIL;
				end
				S_RDPQ: begin
					ra_q <= rank_mem[p_q[AW-1:0]];
					rb_q <= rank_mem[q_q[AW-1:0]];
					a_q <= rank_mem[p_q[AW-1:0]];
					b_q <= rank_mem[q_q[AW-1:0]];
					k_q <= '0;
					st_q <= S_RDTX;
				end
				S_RDTX: begin
					x_q <= text_mem[a_q];
					y_q <= text_mem[b_q];
					st_q <= S_CMP;
				end
				S_CMP: begin
					if (x_q != y_q || {1'b0, k_q} == n_q - 1'b1) begin
						if (x_q > y_q) begin
							tmp_mem[o_q[AW-1:0]] <= rb_q;
							q_q <= q_q + 1'b1;
							o_q <= o_q + 1'b1;
							st_q <= (q_q + 1'b1 < hi_q) ? S_RDPQ : S_TAIL;
						end else begin
							tmp_mem[o_q[AW-1:0]] <= ra_q;
							p_q <= p_q + 1'b1;
							o_q <= o_q + 1'b1;
							st_q <= (p_q + 1'b1 < mid_q) ? S_RDPQ : S_TAIL;
						end
					end else begin
						a_q <= wrap(a_q, n_q);
						b_q <= wrap(b_q, n_q);
						k_q <= k_q + 1'b1;
						st_q <= S_RDTX;
					end
				end
				S_TAIL: begin
					if (p_q < mid_q || q_q < hi_q) begin
						tphase_q <= !tphase_q;
						if (tphase_q) begin
							tmp_mem[o_q[AW-1:0]] <= rk_rd_q;
							o_q <= o_q + 1'b1;
							if (p_q < mid_q) begin
								p_q <= p_q + 1'b1;
							end else begin
								q_q <= q_q + 1'b1;
							end
						end
					end else if (hi_q < n_q) begin
						lo_q <= hi_q;
						st_q <= S_MSET;
					end else begin
						cnt_q <= '0;
						st_q <= S_COPY;
					end
				end
				S_COPY: begin
					tphase_q <= !tphase_q;
					if (tphase_q) begin
						rank_mem[cnt_q] <= tmp_rd_q;
						if ({1'b0, cnt_q} == n_q - 1'b1) begin
							cnt_q <= '0;
							lo_q <= '0;
							if (two_w < n_q) begin
								width_q <= two_w;
								st_q <= S_MSET;
							end else begin
								p_q <= '0;
								st_q <= S_OUTA;
							end
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_OUTA: begin
					p_q <= {1'b0, cnt_q};
					st_q <= S_OUTB;
				end
				S_OUTB: begin
					a_q <= (rk_rd_q == '0) ? last : rk_rd_q - 1'b1;
					st_q <= S_OUTC;
				end
				S_OUTC: begin
					tphase_q <= !tphase_q;
					if (tphase_q) begin
						out_mem[cnt_q] <= ta_q;
						if (ta_q == SymSent) begin
							sent_q <= cnt_q;
						end
						if ({1'b0, cnt_q} == n_q - 1'b1) begin
							st_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							p_q <= {1'b0, cnt_q} + 1'b1;
							st_q <= S_OUTA;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/dna_block_bwt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dna_block_bwt
// Block transform of DNA text: load, finish (rotation sort), read, clear.
// Input channel in_valid/in_stall carries cmd, data_byte and read_index; the
// output channel out_valid/out_stall returns one result item per command.
// Load, clear and a failing finish give their result the cycle after accept;
// a read passes through T_RD1 and T_RD2 before its result is shown.
// Finish runs a merge sort with a single symbol comparator over one set of
// memories: roughly n*log2(n) merge steps, each reading both ranks, then
// fetching and comparing symbol pairs until they differ or all n match;
// leftover moves, the copy back and the output column go row by row.
// The block takes no new item until the result is taken.
// A stalled result holds. Reset empties the block and clears every flag; the
// memories keep their contents and are never read before being written.
// ----------------------------------------------------------------------------
module dna_block_bwt #(
	parameter int unsigned MAX_ROWS = dbwt_pkg::MaxRowsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  data_byte,
	input  wire logic [9:0]  read_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [7:0]       bwt_symbol,
	output logic [9:0]       sentinel_row,
	output logic [10:0]      symbol_count
);
	import dbwt_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ROWS);

	typedef enum logic [4:0] {
		T_IDLE = 5'b00001,
		T_SORT = 5'b00010,
		T_RD1  = 5'b00100,
		T_RD2  = 5'b01000,
		T_OUT  = 5'b10000
	} top_t;

	top_t         st_q;
	logic [AW-1:0] len_q;
	logic         nl_q, tr_q;
	status_t      err_q;
	logic [AW-1:0] sent_q;
	logic [AW-1:0] idx_q;
	logic         txt_we;
	logic [AW-1:0] txt_addr;
	logic [2:0]   txt_wdata, rd_sym;
	logic         sort_start, sort_done;
	logic [AW-1:0] sort_sent;
	logic         acc;
	logic [2:0]   bc;
	logic [AW:0]  n_w;

	assign in_stall = (st_q != T_IDLE);
	assign acc = in_valid && !in_stall;
	assign out_valid = (st_q == T_OUT);
	assign bc = base_code(data_byte);
	assign n_w = {1'b0, len_q} + 1'b1;

	always_comb begin
		txt_we = 1'b0;
		txt_addr = len_q;
		txt_wdata = bc;
		sort_start = 1'b0;
		if (acc && cmd_t'(cmd) == CMD_LOAD && !tr_q && !nl_q && data_byte != ChrNl &&
				bc != SymSent && {1'b0, len_q} < (AW+1)'(MAX_ROWS - 1)) begin
			txt_we = 1'b1;
		end
		if (acc && cmd_t'(cmd) == CMD_FINISH && err_q == ST_OK) begin
			txt_we = 1'b1;
			txt_wdata = SymSent;
			sort_start = 1'b1;
		end
	end

	dbwt_sort #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_sort (
		.clk(clk), .arst_n(arst_n),
		.txt_we(txt_we), .txt_addr(txt_addr), .txt_wdata(txt_wdata),
		.start(sort_start), .last(len_q), .done(sort_done), .sent_row(sort_sent),
		.rd_addr(idx_q), .rd_sym(rd_sym)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
			len_q <= '0;
			nl_q <= 1'b0;
			tr_q <= 1'b0;
			err_q <= ST_OK;
			sent_q <= '0;
		end else begin
			case (st_q)
				T_IDLE: begin
					if (acc) begin
						status <= ST_OK;
						bwt_symbol <= '0;
						sentinel_row <= '0;
						symbol_count <= '0;
						st_q <= T_OUT;
						case (cmd_t'(cmd))
							CMD_LOAD: begin
								if (tr_q) begin
									status <= ST_NRDY;
								end else if (nl_q || (data_byte != ChrNl && bc == SymSent)) begin
									status <= ST_INVAL;
									if (err_q == ST_OK) err_q <= ST_INVAL;
								end else if (data_byte == ChrNl) begin
									nl_q <= 1'b1;
								end else if ({1'b0, len_q} >= (AW+1)'(MAX_ROWS - 1)) begin
									status <= ST_OVFL;
									if (err_q == ST_OK) err_q <= ST_OVFL;
								end else begin
									len_q <= len_q + 1'b1;
								end
							end
							CMD_FINISH: begin
								if (err_q != ST_OK) begin
									status <= err_q;
								end else begin
									st_q <= T_SORT;
								end
							end
							CMD_READ: begin
								if (!tr_q || {1'b0, read_index} >= 11'(n_w)) begin
									status <= ST_NRDY;
								end else begin
									idx_q <= AW'(read_index);
									st_q <= T_RD1;
								end
							end
							default: begin
								len_q <= '0;
								nl_q <= 1'b0;
								tr_q <= 1'b0;
								err_q <= ST_OK;
								sent_q <= '0;
							end
						endcase
					end
				end
				T_SORT: begin
					if (sort_done && !sort_start) begin
						tr_q <= 1'b1;
						sent_q <= sort_sent;
						sentinel_row <= 10'(sort_sent);
						symbol_count <= 11'(n_w);
						st_q <= T_OUT;
					end
				end
				T_RD1: st_q <= T_RD2;
				T_RD2: begin
					bwt_symbol <= code_byte(rd_sym);
					sentinel_row <= 10'(sent_q);
					symbol_count <= 11'(n_w);
					st_q <= T_OUT;
				end
				T_OUT: begin
					if (!out_stall) st_q <= T_IDLE;
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != T_IDLE) |-> !acc) else $error("accept while busy");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status))) else $error("result dropped");
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, len_q} <= (AW+1)'(MAX_ROWS - 1)) else $error("length beyond block");
`endif

endmodule
`default_nettype wire
